// ===== design/csm_pkg.sv =====
// Shared types and constants for the compose sequence matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package csm_pkg;

  localparam int unsigned KeyW       = 29;
  localparam int unsigned RuleKeys   = 4;
  localparam int unsigned KeyIdxW    = $clog2(RuleKeys);
  localparam int unsigned LenW       = 3;
  localparam int unsigned CharW      = 8;
  localparam int unsigned CntW       = 3;
  localparam int unsigned SeqCmpW    = 4;
  localparam int unsigned MaxSeq     = 4;
  localparam int unsigned StoreLimit = (MaxSeq < RuleKeys) ? MaxSeq : RuleKeys;

  localparam logic [KeyW-1:0] KeyShiftLeft  = 29'h0000FFE1;
  localparam logic [KeyW-1:0] KeyShiftRight = 29'h0000FFE2;

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic             operation;
    key_t             key_sym;
    logic [LenW-1:0]  rule_length;
    key_t             rule_key_first;
    key_t             rule_key_second;
    key_t             rule_key_third;
    key_t             rule_key_fourth;
    key_t             rule_output;
  } item_t;

  typedef struct packed {
    logic             pass_through;
    logic             fired;
    logic [CharW-1:0] out_char;
    logic             rejected;
  } result_t;

  typedef struct packed {
    key_t [RuleKeys-1:0] keys;
    logic [LenW-1:0]     len;
    logic [CharW-1:0]    out_char;
  } rule_entry_t;

  typedef struct packed {
    logic capture;
    logic write_rule;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_add;
    logic is_shift;
    logic skip_scan;
    logic scan_last;
  } dp_status_t;

  typedef enum logic [4:0] {
    StIdle     = 5'b00001,
    StDispatch = 5'b00010,
    StScan     = 5'b00100,
    StDrain    = 5'b01000,
    StFinish   = 5'b10000
  } state_e;

endpackage

// ===== design/compose_sequence_matcher_core.sv =====
// Top level of the compose sequence matcher: controller plus datapath.
// Depends on csm_pkg, csm_ctrl, csm_datapath and csm_ram.
//
// An item is taken when start is high and busy is low; its one result appears
// on result_o for exactly one cycle with done_o high, and must be taken then,
// since the block has no way to hold it. Adding a rule, a shift key, a
// key press with an empty table, and a key that overruns the longest sequence
// keep busy high only through the dispatch state after the item is taken.
// Any other key press reads every stored rule from the rule RAM, one entry
// per cycle through its single read port in the scan state, then passes
// through the drain and finish states before busy falls. The result shows
// in the same cycle that busy falls.
module compose_sequence_matcher_core #(
  parameter int unsigned MAX_RULES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  csm_pkg::item_t    item_i,
  output csm_pkg::result_t  result_o,
  output logic              done_o
);

  csm_pkg::ctrl_cmd_t  cmd;
  csm_pkg::dp_status_t status;

  csm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  csm_datapath #(
    .MAX_RULES (MAX_RULES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// ===== design/csm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module csm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/csm_ctrl.sv =====
// Controller state machine for the compose sequence matcher.
// Depends on csm_pkg for the state, command and status types.
module csm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  csm_pkg::dp_status_t   status_i,
  output csm_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o
);

  csm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      csm_pkg::StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = csm_pkg::StDispatch;
        end
      end
      csm_pkg::StDispatch: begin
        if (status_i.op_add) begin
          cmd_o.write_rule = 1'b1;
          cmd_o.finish     = 1'b1;
          state_d          = csm_pkg::StIdle;
        end else if (status_i.is_shift || status_i.skip_scan) begin
          cmd_o.finish = 1'b1;
          state_d      = csm_pkg::StIdle;
        end else begin
          state_d = csm_pkg::StScan;
        end
      end
      csm_pkg::StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = csm_pkg::StDrain;
        end
      end
      // The last rule read is evaluated here.
      csm_pkg::StDrain: begin
        state_d = csm_pkg::StFinish;
      end
      csm_pkg::StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = csm_pkg::StIdle;
      end
      default: begin
        state_d = csm_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != csm_pkg::StIdle);

endmodule

// ===== design/csm_datapath.sv =====
// Datapath of the compose sequence matcher: rule table, typed sequence,
// scan evaluation and result register. Depends on csm_pkg and csm_ram.
module csm_datapath #(
  parameter int unsigned MAX_RULES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csm_pkg::item_t       item_i,
  input  csm_pkg::ctrl_cmd_t   cmd_i,
  output csm_pkg::dp_status_t  status_o,
  output csm_pkg::result_t     result_o,
  output logic                 done_o
);

  localparam int unsigned AddrW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned TotalW = $clog2(MAX_RULES + 1);
  localparam int unsigned EntryW = $bits(csm_pkg::rule_entry_t);

  csm_pkg::item_t                 item_q;
  logic [TotalW-1:0]              total_q, total_d;
  logic [AddrW-1:0]               idx_q, idx_d;
  logic                           rvalid_q;
  logic                           exact_q, exact_d;
  logic                           prefix_q, prefix_d;
  logic [csm_pkg::CharW-1:0]      char_q, char_d;
  logic                           collecting_q, collecting_d;
  logic [csm_pkg::CntW-1:0]       cnt_q, cnt_d;
  csm_pkg::key_t [csm_pkg::RuleKeys-1:0] typed_q, typed_d;
  csm_pkg::result_t               result_q, result_d;
  logic                           done_q;

  logic                           table_full;
  logic                           seq_full;
  logic                           is_shift;
  logic                           do_write;
  logic [csm_pkg::LenW-1:0]       len_clamped;
  csm_pkg::rule_entry_t           wr_entry;
  csm_pkg::rule_entry_t           rd_entry;
  logic [EntryW-1:0]              rd_data;
  logic [csm_pkg::SeqCmpW-1:0]    seq_len;
  logic [csm_pkg::SeqCmpW-1:0]    rule_len;
  logic                           keys_ok;
  logic                           rel_any;
  logic                           rel_exact;

  assign table_full = (total_q == TotalW'(MAX_RULES));
  assign seq_full   = collecting_q &&
                      ({1'b0, cnt_q} >= csm_pkg::SeqCmpW'(csm_pkg::MaxSeq));
  assign is_shift   = (item_q.key_sym == csm_pkg::KeyShiftLeft) ||
                      (item_q.key_sym == csm_pkg::KeyShiftRight);
  assign do_write   = cmd_i.write_rule && !table_full;

  assign status_o.op_add    = item_q.operation;
  assign status_o.is_shift  = is_shift;
  assign status_o.skip_scan = (total_q == '0) || seq_full;
  assign status_o.scan_last = ((TotalW'(idx_q) + TotalW'(1)) == total_q);

  // A rule length of zero counts as one; longer ones are cut to the limit.
  always_comb begin
    if (item_q.rule_length == '0) begin
      len_clamped = csm_pkg::LenW'(1);
    end else if (item_q.rule_length > csm_pkg::LenW'(csm_pkg::StoreLimit)) begin
      len_clamped = csm_pkg::LenW'(csm_pkg::StoreLimit);
    end else begin
      len_clamped = item_q.rule_length;
    end
  end

  always_comb begin
    wr_entry          = '0;
    wr_entry.keys[0]  = item_q.rule_key_first;
    wr_entry.keys[1]  = item_q.rule_key_second;
    wr_entry.keys[2]  = item_q.rule_key_third;
    wr_entry.keys[3]  = item_q.rule_key_fourth;
    wr_entry.len      = len_clamped;
    wr_entry.out_char = item_q.rule_output[csm_pkg::CharW-1:0];
  end

  csm_ram #(
    .Width (EntryW),
    .Depth (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (total_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign rd_entry = csm_pkg::rule_entry_t'(rd_data);

  // The candidate sequence is the typed keys followed by the new key. When idle
  // it is the new key alone, and any relation means the key starts a rule.
  assign seq_len  = collecting_q ? ({1'b0, cnt_q} + csm_pkg::SeqCmpW'(1))
                                 : csm_pkg::SeqCmpW'(1);
  assign rule_len = {1'b0, rd_entry.len};

  always_comb begin
    csm_pkg::key_t cand;
    keys_ok = 1'b1;
    for (int i = 0; i < int'(csm_pkg::RuleKeys); i++) begin
      if (collecting_q && (csm_pkg::CntW'(i) < cnt_q)) begin
        cand = typed_q[i];
      end else begin
        cand = item_q.key_sym;
      end
      if ((csm_pkg::SeqCmpW'(i) < seq_len) && (rd_entry.keys[i] != cand)) begin
        keys_ok = 1'b0;
      end
    end
  end

  assign rel_any   = keys_ok && (seq_len <= rule_len);
  assign rel_exact = rel_any && (seq_len == rule_len);

  always_comb begin
    exact_d  = exact_q;
    prefix_d = prefix_q;
    char_d   = char_q;
    idx_d    = idx_q;
    if (cmd_i.capture) begin
      exact_d  = 1'b0;
      prefix_d = 1'b0;
      idx_d    = '0;
    end else begin
      if (cmd_i.scan_rd) begin
        idx_d = idx_q + AddrW'(1);
      end
      // Only the earliest exact match supplies the character.
      if (rvalid_q && rel_exact && !exact_q) begin
        exact_d = 1'b1;
        char_d  = rd_entry.out_char;
      end
      if (rvalid_q && rel_any) begin
        prefix_d = 1'b1;
      end
    end
  end

  always_comb begin
    total_d      = total_q;
    collecting_d = collecting_q;
    cnt_d        = cnt_q;
    typed_d      = typed_q;
    result_d     = result_q;
    if (do_write) begin
      total_d = total_q + TotalW'(1);
    end
    if (cmd_i.finish) begin
      result_d = '0;
      if (item_q.operation) begin
        result_d.rejected = table_full;
      end else if (is_shift) begin
        result_d.pass_through = 1'b1;
      end else if (!collecting_q) begin
        if (exact_q || prefix_q) begin
          collecting_d = 1'b1;
          typed_d[0]   = item_q.key_sym;
          cnt_d        = csm_pkg::CntW'(1);
        end else begin
          result_d.pass_through = 1'b1;
        end
      end else if (seq_full) begin
        collecting_d          = 1'b0;
        cnt_d                 = '0;
        result_d.pass_through = 1'b1;
      end else if (exact_q) begin
        collecting_d          = 1'b0;
        cnt_d                 = '0;
        result_d.pass_through = 1'b1;
        result_d.fired        = 1'b1;
        result_d.out_char     = char_q;
      end else if (prefix_q) begin
        typed_d[cnt_q[csm_pkg::KeyIdxW-1:0]] = item_q.key_sym;
        cnt_d = cnt_q + csm_pkg::CntW'(1);
      end else begin
        collecting_d          = 1'b0;
        cnt_d                 = '0;
        result_d.pass_through = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      idx_q        <= '0;
      rvalid_q     <= 1'b0;
      exact_q      <= 1'b0;
      prefix_q     <= 1'b0;
      collecting_q <= 1'b0;
      cnt_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      total_q      <= total_d;
      idx_q        <= idx_d;
      rvalid_q     <= cmd_i.scan_rd;
      exact_q      <= exact_d;
      prefix_q     <= prefix_d;
      collecting_q <= collecting_d;
      cnt_q        <= cnt_d;
      done_q       <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    char_q   <= char_d;
    typed_q  <= typed_d;
    result_q <= result_d;
  end

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for compose_sequence_matcher_core.
// Holds its own model of the rule table and the typing state, and checks every result.
// Depends on csm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxRules   = 128;
  localparam int unsigned CycleLimit = 1_000_000;

  localparam logic OpKeyPress = 1'b0;
  localparam logic OpAddRule  = 1'b1;

  localparam csm_pkg::key_t KeyZero = 29'h00000000;
  localparam csm_pkg::key_t KeyTop  = 29'h1FFFFFFF;
  localparam csm_pkg::key_t KeyA    = 29'h00000061;
  localparam csm_pkg::key_t KeyE    = 29'h00000065;
  localparam csm_pkg::key_t KeyDead = 29'h0000FE51;

  typedef enum int {RelNone, RelExact, RelPrefix} rule_rel_e;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  csm_pkg::item_t   item_i;
  csm_pkg::result_t result_o;
  logic             done_o;

  compose_sequence_matcher_core #(
    .MAX_RULES(MaxRules)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .result_o(result_o),
    .done_o  (done_o)
  );

  // Model of the rule table and the typing state.
  csm_pkg::key_t rule_key_tab [MaxRules][csm_pkg::RuleKeys];
  logic [2:0]    rule_len_tab [MaxRules];
  logic [7:0]    rule_char_tab[MaxRules];
  int unsigned   rule_cnt;
  bit            composing;
  csm_pkg::key_t typed_keys[csm_pkg::MaxSeq];
  int unsigned   typed_n;

  csm_pkg::result_t pending_results[$];
  csm_pkg::key_t    key_pool[8];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_fired;
  int unsigned n_refused;
  int unsigned burst_left;
  bit          gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void clear_typing();
    composing = 1'b0;
    typed_n   = 0;
    foreach (typed_keys[i]) typed_keys[i] = '0;
  endfunction

  function automatic rule_rel_e rule_relation(input int unsigned r);
    if (typed_n > 32'(rule_len_tab[r])) return RelNone;
    for (int unsigned i = 0; i < typed_n; i++) begin
      if (rule_key_tab[r][i] != typed_keys[i]) return RelNone;
    end
    return (typed_n == 32'(rule_len_tab[r])) ? RelExact : RelPrefix;
  endfunction

  // Works out the result of one item and advances the model state.
  function automatic csm_pkg::result_t compose_predict(input csm_pkg::item_t it);
    csm_pkg::result_t res;
    int unsigned      len;
    bit               prefix_hit;
    rule_rel_e        rel;
    res = '0;
    prefix_hit = 1'b0;
    if (it.operation == OpAddRule) begin
      if (rule_cnt >= MaxRules) begin
        res.rejected = 1'b1;
        n_refused++;
        return res;
      end
      len = 32'(it.rule_length);
      if (len == 0) len = 1;
      if (len > csm_pkg::StoreLimit) len = csm_pkg::StoreLimit;
      rule_key_tab[rule_cnt][0] = it.rule_key_first;
      rule_key_tab[rule_cnt][1] = it.rule_key_second;
      rule_key_tab[rule_cnt][2] = it.rule_key_third;
      rule_key_tab[rule_cnt][3] = it.rule_key_fourth;
      rule_len_tab[rule_cnt]    = len[2:0];
      rule_char_tab[rule_cnt]   = it.rule_output[7:0];
      rule_cnt++;
      return res;
    end
    if (it.key_sym == csm_pkg::KeyShiftLeft || it.key_sym == csm_pkg::KeyShiftRight) begin
      res.pass_through = 1'b1;
      return res;
    end
    if (!composing) begin
      for (int unsigned r = 0; r < rule_cnt; r++) begin
        if (rule_key_tab[r][0] == it.key_sym) begin
          clear_typing();
          composing     = 1'b1;
          typed_keys[0] = it.key_sym;
          typed_n       = 1;
          return res;
        end
      end
      res.pass_through = 1'b1;
      return res;
    end
    if (typed_n >= csm_pkg::MaxSeq) begin
      clear_typing();
      res.pass_through = 1'b1;
      return res;
    end
    typed_keys[typed_n] = it.key_sym;
    typed_n++;
    for (int unsigned r = 0; r < rule_cnt; r++) begin
      rel = rule_relation(r);
      if (rel == RelExact) begin
        res.pass_through = 1'b1;
        res.fired        = 1'b1;
        res.out_char     = rule_char_tab[r];
        clear_typing();
        return res;
      end
      if (rel == RelPrefix) prefix_hit = 1'b1;
    end
    if (prefix_hit) return res;
    clear_typing();
    res.pass_through = 1'b1;
    return res;
  endfunction

  function automatic csm_pkg::item_t rand_item();
    csm_pkg::item_t it;
    it.operation       = 1'($urandom_range(0, 1));
    it.key_sym         = csm_pkg::key_t'($urandom());
    it.rule_length     = 3'($urandom_range(0, 7));
    it.rule_key_first  = csm_pkg::key_t'($urandom());
    it.rule_key_second = csm_pkg::key_t'($urandom());
    it.rule_key_third  = csm_pkg::key_t'($urandom());
    it.rule_key_fourth = csm_pkg::key_t'($urandom());
    it.rule_output     = csm_pkg::key_t'($urandom());
    return it;
  endfunction

  function automatic csm_pkg::item_t key_item(input csm_pkg::key_t k);
    csm_pkg::item_t it;
    it = rand_item();
    it.operation = OpKeyPress;
    it.key_sym   = k;
    return it;
  endfunction

  function automatic csm_pkg::item_t rule_item(input logic [2:0] len,
                                               input csm_pkg::key_t k0,
                                               input csm_pkg::key_t k1,
                                               input csm_pkg::key_t k2,
                                               input csm_pkg::key_t k3,
                                               input csm_pkg::key_t outk);
    csm_pkg::item_t it;
    it = rand_item();
    it.operation       = OpAddRule;
    it.rule_length     = len;
    it.rule_key_first  = k0;
    it.rule_key_second = k1;
    it.rule_key_third  = k2;
    it.rule_key_fourth = k3;
    it.rule_output     = outk;
    return it;
  endfunction

  function automatic csm_pkg::key_t pool_key();
    return key_pool[3'($urandom_range(0, 7))];
  endfunction

  function automatic csm_pkg::item_t pool_rule_item();
    return rule_item(3'($urandom_range(0, 7)), pool_key(), pool_key(), pool_key(), pool_key(),
                     csm_pkg::key_t'($urandom()));
  endfunction

  // Drives one item from the falling edge and returns at the falling edge after it is taken.
  task automatic send_item(input csm_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gaps_on    = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(10, 60);
    end
    burst_left--;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(compose_predict(it));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Types the keys of a stored rule, sometimes only a prefix, with stray shifts now and then.
  task automatic type_stored_rule();
    int unsigned r;
    int unsigned len;
    int unsigned n_keys;
    r      = $urandom_range(0, rule_cnt - 1);
    len    = 32'(rule_len_tab[r]);
    n_keys = ($urandom_range(0, 9) < 7) ? len : $urandom_range(1, len);
    for (int unsigned i = 0; i < n_keys; i++) begin
      send_item(key_item(rule_key_tab[r][i]));
      if ($urandom_range(0, 9) == 0)
        send_item(key_item($urandom_range(0, 1) ? csm_pkg::KeyShiftLeft
                                                : csm_pkg::KeyShiftRight));
    end
    if ($urandom_range(0, 4) == 0) send_item(key_item(pool_key()));
  endtask

  task automatic random_mix(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_item(pool_rule_item());
      end else if (pick < 75 && rule_cnt > 0) begin
        type_stored_rule();
      end else if (pick < 88) begin
        send_item(key_item(pool_key()));
      end else begin
        send_item(rand_item());
      end
    end
  endtask

  task automatic test_empty_table();
    send_item(key_item(KeyZero));
    send_item(key_item(KeyTop));
    send_item(key_item(csm_pkg::KeyShiftLeft));
    send_item(key_item(csm_pkg::KeyShiftRight));
  endtask

  task automatic test_rule_store();
    send_item(rule_item(3'd2, KeyA, KeyE, KeyZero, KeyZero, KeyTop));
    // A zero length is stored as one, an oversize length as the longest sequence.
    send_item(rule_item(3'd0, KeyTop, KeyA, KeyA, KeyA, 29'h00000041));
    send_item(rule_item(3'd7, KeyDead, KeyA, KeyE, KeyZero, 29'h00000100));
    send_item(rule_item(3'd2, KeyA, KeyE, KeyTop, KeyTop, 29'h000000E9));
    send_item(rule_item(3'd5, KeyDead, KeyE, KeyA, KeyTop, 29'h01234567));
    send_item(rule_item(3'd1, csm_pkg::KeyShiftLeft, KeyZero, KeyZero, KeyZero,
                        29'h1555AAAA));
  endtask

  task automatic test_directed_compose();
    // A shift in the middle of a sequence passes and is not appended.
    send_item(key_item(KeyA));
    send_item(key_item(csm_pkg::KeyShiftLeft));
    send_item(key_item(KeyE));
    // A one-key rule only starts collecting, and the next key breaks it.
    send_item(key_item(KeyTop));
    send_item(key_item(KeyA));
    send_item(key_item(KeyDead));
    send_item(key_item(KeyA));
    send_item(key_item(KeyE));
    send_item(key_item(KeyZero));
    send_item(key_item(KeyDead));
    send_item(key_item(KeyE));
    send_item(key_item(KeyA));
    send_item(key_item(KeyTop));
    send_item(key_item(KeyDead));
    send_item(key_item(KeyA));
    send_item(key_item(KeyTop));
    send_item(key_item(KeyE));
  endtask

  task automatic test_random_typing();
    key_pool[0] = KeyZero;
    key_pool[1] = KeyTop;
    for (int i = 2; i < 8; i++) key_pool[i] = csm_pkg::key_t'($urandom());
    random_mix(750);
  endtask

  task automatic test_table_full();
    while (rule_cnt < MaxRules) send_item(pool_rule_item());
    repeat (4) send_item(pool_rule_item());
    send_item(rand_item());
    random_mix(220);
  endtask

  always @(posedge clk_i) begin : result_check
    csm_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_error("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result_o.fired === 1'b1) n_fired++;
        if (result_o.pass_through !== want.pass_through)
          report_error($sformatf("pass_through %b, want %b", result_o.pass_through,
                                 want.pass_through));
        if (result_o.fired !== want.fired)
          report_error($sformatf("fired %b, want %b", result_o.fired, want.fired));
        if (result_o.out_char !== want.out_char)
          report_error($sformatf("out_char %h, want %h", result_o.out_char, want.out_char));
        if (result_o.rejected !== want.rejected)
          report_error($sformatf("rejected %b, want %b", result_o.rejected, want.rejected));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_fired    = 0;
    n_refused  = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    rule_cnt   = 0;
    clear_typing();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_rule_store();
    test_directed_compose();
    test_random_typing();
    // Hold the next item back until every outstanding result is in.
    wait_drained();
    test_table_full();

    wait_drained();
    repeat (MaxRules + 8) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results; %0d rules stored, %0d refused.",
             n_sent, n_checked, rule_cnt, n_refused);
    $display("Composed characters seen: %0d; mismatches: %0d.", n_fired, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
